// File: rtl/core/sri_pkg.sv
package sri_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int EXT_BITS       = 15;
  localparam int OUT_BITS       = 24;
  localparam int OUT_DATA_BITS  = 2 * OUT_BITS;
  localparam int OUT_USER_BITS  = 3;

  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_TOP    = 2'd1;
  localparam logic [1:0] EDGE_RIGHT  = 2'd2;
  localparam logic [1:0] EDGE_BOTTOM = 2'd3;

  typedef struct packed {
    logic       vld;
    logic       hit;
    logic [1:0] edge_sel;
    logic       neg;
  } sri_ctl_t;

  // input fields packed and padded to whole bytes
  function automatic int in_data_bits(int cb);
    return ((6 * cb + 2 * EXT_BITS + 7) / 8) * 8;
  endfunction

  // width of a coordinate plus an extent, with room for the carry
  function automatic int sum_bits(int cb);
    return ((cb > EXT_BITS + 1) ? cb : EXT_BITS + 1) + 1;
  endfunction

endpackage

// File: rtl/core/sri_edge.sv
module sri_edge #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF,
  localparam int GW = sri_pkg::sum_bits(COORD_BITS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [COORD_BITS-1:0]  seg_start_x,
  input  logic signed [COORD_BITS-1:0]  seg_start_y,
  input  logic signed [COORD_BITS-1:0]  seg_end_x,
  input  logic signed [COORD_BITS-1:0]  seg_end_y,
  input  logic signed [COORD_BITS-1:0]  rect_x,
  input  logic signed [COORD_BITS-1:0]  rect_y,
  input  logic [sri_pkg::EXT_BITS-1:0]  rect_w,
  input  logic [sri_pkg::EXT_BITS-1:0]  rect_h,
  output sri_pkg::sri_ctl_t             ctl,
  output logic [COORD_BITS-1:0]         div_d,
  output logic [COORD_BITS-1:0]         num_a,
  output logic [COORD_BITS-1:0]         num_b,
  output logic signed [COORD_BITS-1:0]  base,
  output logic signed [GW-1:0]          along
);
  import sri_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int SW = C + 1;
  localparam int DW = GW + 1;
  localparam int PW = DW + SW;
  localparam int KW = PW + 1;

  function automatic logic [C-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[C-1:0];
  endfunction

  // v lies between zero and lim, both ends included; lim of zero never matches
  function automatic logic between(input logic signed [KW-1:0] v,
                                   input logic signed [KW-1:0] lim);
    logic r;
    if (lim > 0) r = (v >= 0) && (v <= lim);
    else if (lim < 0) r = (v <= 0) && (v >= lim);
    else r = 1'b0;
    return r;
  endfunction

  // stage 1: differences
  logic                 v1_r;
  logic signed [SW-1:0] s1x1_r, s1y1_r, dax1_r, day1_r;
  logic signed [DW-1:0] dl1_r, dr1_r, dt1_r, db1_r;
  logic signed [GW-1:0] xl1_r, xr1_r, yt1_r, yb1_r;
  logic signed [C-1:0]  ax1_r, ay1_r;
  logic [EXT_BITS-1:0]  w1_r, h1_r;
  logic signed [GW-1:0] xr_nxt, yt_nxt;

  assign xr_nxt = GW'(rect_x) + GW'(signed'({1'b0, rect_w}));
  assign yt_nxt = GW'(rect_y) + GW'(signed'({1'b0, rect_h}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1x1_r <= SW'(seg_end_x) - SW'(seg_start_x);
      s1y1_r <= SW'(seg_end_y) - SW'(seg_start_y);
      dax1_r <= SW'(seg_start_x) - SW'(rect_x);
      day1_r <= SW'(seg_start_y) - SW'(rect_y);
      dl1_r  <= DW'(rect_x) - DW'(seg_start_x);
      dr1_r  <= DW'(xr_nxt) - DW'(seg_start_x);
      dt1_r  <= DW'(yt_nxt) - DW'(seg_start_y);
      db1_r  <= DW'(rect_y) - DW'(seg_start_y);
      xl1_r  <= GW'(rect_x);
      xr1_r  <= xr_nxt;
      yt1_r  <= yt_nxt;
      yb1_r  <= GW'(rect_y);
      ax1_r  <= seg_start_x;
      ay1_r  <= seg_start_y;
      w1_r   <= rect_w;
      h1_r   <= rect_h;
    end
  end

  // stage 2: products and magnitudes
  logic                     v2_r;
  logic signed [PW-1:0]     pay2_r, pdl2_r, pdr2_r, hx2_r;
  logic signed [PW-1:0]     pax2_r, pdt2_r, pdb2_r, wy2_r;
  logic signed [SW-1:0]     s1x2_r, s1y2_r;
  logic signed [DW-1:0]     dl2_r, dr2_r, dt2_r, db2_r;
  logic [C-1:0]             as1x2_r, as1y2_r, adl2_r, adr2_r, adt2_r, adb2_r;
  logic signed [C-1:0]      ax2_r, ay2_r;
  logic signed [GW-1:0]     xl2_r, xr2_r, yt2_r, yb2_r;
  logic signed [EXT_BITS:0] hs, ws;
  logic signed [PW-1:0]     pay_nxt, pdl_nxt, pdr_nxt, hx_nxt;
  logic signed [PW-1:0]     pax_nxt, pdt_nxt, pdb_nxt, wy_nxt;

  assign hs      = signed'({1'b0, h1_r});
  assign ws      = signed'({1'b0, w1_r});
  assign pay_nxt = day1_r * s1x1_r;
  assign pdl_nxt = dl1_r * s1y1_r;
  assign pdr_nxt = dr1_r * s1y1_r;
  assign hx_nxt  = hs * s1x1_r;
  assign pax_nxt = dax1_r * s1y1_r;
  assign pdt_nxt = dt1_r * s1x1_r;
  assign pdb_nxt = db1_r * s1x1_r;
  assign wy_nxt  = ws * s1y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay2_r  <= pay_nxt;
      pdl2_r  <= pdl_nxt;
      pdr2_r  <= pdr_nxt;
      hx2_r   <= hx_nxt;
      pax2_r  <= pax_nxt;
      pdt2_r  <= pdt_nxt;
      pdb2_r  <= pdb_nxt;
      wy2_r   <= wy_nxt;
      s1x2_r  <= s1x1_r;
      s1y2_r  <= s1y1_r;
      dl2_r   <= dl1_r;
      dr2_r   <= dr1_r;
      dt2_r   <= dt1_r;
      db2_r   <= db1_r;
      as1x2_r <= mag(DW'(s1x1_r));
      as1y2_r <= mag(DW'(s1y1_r));
      adl2_r  <= mag(dl1_r);
      adr2_r  <= mag(dr1_r);
      adt2_r  <= mag(dt1_r);
      adb2_r  <= mag(db1_r);
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
      xl2_r   <= xl1_r;
      xr2_r   <= xr1_r;
      yt2_r   <= yt1_r;
      yb2_r   <= yb1_r;
    end
  end

  // stage 3: range tests per edge; of the edges hit, left has priority, then top, right, bottom
  logic signed [KW-1:0] kl, kr, kt, kb;
  logic                 hit_l, hit_t, hit_r, hit_b;
  sri_ctl_t             ctl_nxt, ctl3_r;
  logic [C-1:0]         d_nxt, na_nxt, nb_nxt, d3_r, na3_r, nb3_r;
  logic signed [C-1:0]  base_nxt, base3_r;
  logic signed [GW-1:0] along_nxt, along3_r;

  // crossing offset along the edge, scaled by the segment slope term
  assign kl = KW'(pay2_r) + KW'(pdl2_r);
  assign kr = KW'(pay2_r) + KW'(pdr2_r);
  assign kt = KW'(pax2_r) + KW'(pdt2_r);
  assign kb = KW'(pax2_r) + KW'(pdb2_r);

  assign hit_l = between(kl, KW'(hx2_r)) && between(KW'(dl2_r), KW'(s1x2_r));
  assign hit_r = between(kr, KW'(hx2_r)) && between(KW'(dr2_r), KW'(s1x2_r));
  assign hit_t = between(kt, KW'(wy2_r)) && between(KW'(dt2_r), KW'(s1y2_r));
  assign hit_b = between(kb, KW'(wy2_r)) && between(KW'(db2_r), KW'(s1y2_r));

  always_comb begin
    ctl_nxt.vld      = v2_r;
    ctl_nxt.hit      = hit_l | hit_t | hit_r | hit_b;
    ctl_nxt.edge_sel = EDGE_LEFT;
    ctl_nxt.neg      = s1y2_r < 0;
    d_nxt            = as1x2_r;
    na_nxt           = adl2_r;
    nb_nxt           = as1y2_r;
    base_nxt         = ay2_r;
    along_nxt        = xl2_r;
    if (hit_l) begin
      ctl_nxt.edge_sel = EDGE_LEFT;
    end else if (hit_t) begin
      ctl_nxt.edge_sel = EDGE_TOP;
      ctl_nxt.neg      = s1x2_r < 0;
      d_nxt            = as1y2_r;
      na_nxt           = adt2_r;
      nb_nxt           = as1x2_r;
      base_nxt         = ax2_r;
      along_nxt        = yt2_r;
    end else if (hit_r) begin
      ctl_nxt.edge_sel = EDGE_RIGHT;
      na_nxt           = adr2_r;
      along_nxt        = xr2_r;
    end else if (hit_b) begin
      ctl_nxt.edge_sel = EDGE_BOTTOM;
      ctl_nxt.neg      = s1x2_r < 0;
      d_nxt            = as1y2_r;
      na_nxt           = adb2_r;
      nb_nxt           = as1x2_r;
      base_nxt         = ax2_r;
      along_nxt        = yb2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (en) begin
      ctl3_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r     <= d_nxt;
      na3_r    <= na_nxt;
      nb3_r    <= nb_nxt;
      base3_r  <= base_nxt;
      along3_r <= along_nxt;
    end
  end

  assign ctl   = ctl3_r;
  assign div_d = d3_r;
  assign num_a = na3_r;
  assign num_b = nb3_r;
  assign base  = base3_r;
  assign along = along3_r;

endmodule

// File: rtl/core/sri_div.sv
module sri_div #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sri_pkg::FRAC_BITS_DEF,
  localparam int GW = sri_pkg::sum_bits(COORD_BITS),
  localparam int QW = COORD_BITS + FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  sri_pkg::sri_ctl_t            ctl_i,
  input  logic [COORD_BITS-1:0]        div_d,
  input  logic [COORD_BITS-1:0]        num_a,
  input  logic [COORD_BITS-1:0]        num_b,
  input  logic signed [COORD_BITS-1:0] base_i,
  input  logic signed [GW-1:0]         along_i,
  output sri_pkg::sri_ctl_t            ctl_o,
  output logic [QW-1:0]                quo,
  output logic                         frac,
  output logic signed [COORD_BITS-1:0] base_o,
  output logic signed [GW-1:0]         along_o
);
  import sri_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int NW = 2 * C + FRAC_BITS;

  // product stage
  sri_ctl_t             ctlm_r;
  logic [2*C-1:0]       prod_r;
  logic [C-1:0]         dm_r;
  logic signed [C-1:0]  basem_r;
  logic signed [GW-1:0] alongm_r;
  logic [NW-1:0]        num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlm_r <= '0;
    end else if (en) begin
      ctlm_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= num_a * num_b;
      dm_r     <= div_d;
      basem_r  <= base_i;
      alongm_r <= along_i;
    end
  end

  assign num = NW'(prod_r) << FRAC_BITS;

  // one quotient bit per stage, restoring
  sri_ctl_t             ctl_in   [0:QW];
  logic [C-1:0]         rem_in   [0:QW];
  logic [QW-1:0]        nq_in    [0:QW];
  logic [C-1:0]         d_in     [0:QW];
  logic signed [C-1:0]  base_in  [0:QW];
  logic signed [GW-1:0] along_in [0:QW];

  sri_ctl_t             ctl_r    [0:QW-1];
  logic [C-1:0]         rem_r    [0:QW-1];
  logic [QW-1:0]        nq_r     [0:QW-1];
  logic [C-1:0]         d_r      [0:QW-1];
  logic signed [C-1:0]  base_r   [0:QW-1];
  logic signed [GW-1:0] along_r  [0:QW-1];

  assign ctl_in[0]   = ctlm_r;
  assign rem_in[0]   = num[NW-1:QW];
  assign nq_in[0]    = num[QW-1:0];
  assign d_in[0]     = dm_r;
  assign base_in[0]  = basem_r;
  assign along_in[0] = alongm_r;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [C:0] cand, diff;

    assign cand = {rem_in[i], nq_in[i][QW-1]};
    assign diff = cand - {1'b0, d_in[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]   <= diff[C] ? cand[C-1:0] : diff[C-1:0];
        nq_r[i]    <= {nq_in[i][QW-2:0], ~diff[C]};
        d_r[i]     <= d_in[i];
        base_r[i]  <= base_in[i];
        along_r[i] <= along_in[i];
      end
    end

    assign ctl_in[i+1]   = ctl_r[i];
    assign rem_in[i+1]   = rem_r[i];
    assign nq_in[i+1]    = nq_r[i];
    assign d_in[i+1]     = d_r[i];
    assign base_in[i+1]  = base_r[i];
    assign along_in[i+1] = along_r[i];
  end

  assign ctl_o   = ctl_in[QW];
  assign quo     = nq_in[QW];
  assign frac    = rem_in[QW] != '0;
  assign base_o  = base_in[QW];
  assign along_o = along_in[QW];

endmodule

// File: rtl/core/sri_place.sv
module sri_place #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sri_pkg::FRAC_BITS_DEF,
  localparam int GW = sri_pkg::sum_bits(COORD_BITS),
  localparam int QW = COORD_BITS + FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  sri_pkg::sri_ctl_t                  ctl_i,
  input  logic [QW-1:0]                      quo,
  input  logic                               frac,
  input  logic signed [COORD_BITS-1:0]       base_i,
  input  logic signed [GW-1:0]               along_i,
  output sri_pkg::sri_ctl_t                  ctl_o,
  output logic signed [sri_pkg::OUT_BITS-1:0] point_x,
  output logic signed [sri_pkg::OUT_BITS-1:0] point_y
);
  import sri_pkg::*;

  localparam int VW  = COORD_BITS + FRAC_BITS + 2;
  localparam int AW  = GW + FRAC_BITS;
  localparam int XW0 = (VW > AW) ? VW : AW;
  localparam int XW  = (XW0 > OUT_BITS) ? XW0 : OUT_BITS;
  localparam logic signed [XW-1:0] SAT_HI = (XW'(1) <<< (OUT_BITS - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    if (v > SAT_HI) r = SAT_HI;
    else if (v < SAT_LO) r = SAT_LO;
    else r = v;
    return r[OUT_BITS-1:0];
  endfunction

  logic signed [VW-1:0]       bf, qv, v;
  logic signed [AW-1:0]       al;
  logic signed [OUT_BITS-1:0] vs, als;
  logic signed [OUT_BITS-1:0] px_nxt, py_nxt;
  sri_ctl_t                   ctl_r;
  logic signed [OUT_BITS-1:0] px_r, py_r;

  assign bf = VW'(base_i) <<< FRAC_BITS;
  assign qv = signed'(VW'(quo));
  assign al = AW'(along_i) <<< FRAC_BITS;

  // truncate toward zero: pull a non-integer result one step back to zero
  always_comb begin
    if (ctl_i.neg) begin
      v = bf - qv;
      if (v > 0 && frac) v = v - VW'(1);
    end else begin
      v = bf + qv;
      if (v < 0 && frac) v = v + VW'(1);
    end
  end

  assign vs  = sat(XW'(v));
  assign als = sat(XW'(al));

  always_comb begin
    px_nxt = '0;
    py_nxt = '0;
    if (ctl_i.hit) begin
      if (ctl_i.edge_sel == EDGE_LEFT || ctl_i.edge_sel == EDGE_RIGHT) begin
        px_nxt = als;
        py_nxt = vs;
      end else begin
        px_nxt = vs;
        py_nxt = als;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign point_x = px_r;
  assign point_y = py_r;

endmodule

// File: rtl/core/segment_rectangle_intersect.sv
// pipeline from input transfer to out_tvalid: three test stages, one product
// stage, one divider stage per quotient bit, one placement stage and the output
// register
// throughput: one item per cycle; a stall holds the whole pipe and a skid
// register takes the one item already on its way out
// reset: synchronous active-low rst_n clears every valid bit, no clearing pass
module segment_rectangle_intersect #(
  parameter int COORD_BITS = sri_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sri_pkg::FRAC_BITS_DEF,
  localparam int IN_W = sri_pkg::in_data_bits(COORD_BITS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, rect_x, rect_y, rect_w, rect_h
  input  logic [IN_W-1:0]                   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // point_x, point_y
  output logic [sri_pkg::OUT_DATA_BITS-1:0] out_tdata,
  // hit, edge_res
  output logic [sri_pkg::OUT_USER_BITS-1:0] out_tuser
);
  import sri_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int GW = sum_bits(COORD_BITS);
  localparam int QW = COORD_BITS + FRAC_BITS;

  logic                      en;
  sri_ctl_t                  e_ctl, d_ctl, p_ctl;
  logic [C-1:0]              e_d, e_na, e_nb;
  logic signed [C-1:0]       e_base, d_base;
  logic signed [GW-1:0]      e_along, d_along;
  logic [QW-1:0]             d_quo;
  logic                      d_frac;
  logic signed [OUT_BITS-1:0] p_px, p_py;

  logic                      out_vld_r, out_hit_r, sk_vld_r, sk_hit_r;
  logic [1:0]                out_edge_r, sk_edge_r;
  logic signed [OUT_BITS-1:0] out_px_r, out_py_r, sk_px_r, sk_py_r;

  assign en        = !sk_vld_r;
  assign in_tready = en;

  sri_edge #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (in_tvalid),
    .seg_start_x (signed'(in_tdata[C-1:0])),
    .seg_start_y (signed'(in_tdata[2*C-1:C])),
    .seg_end_x   (signed'(in_tdata[3*C-1:2*C])),
    .seg_end_y   (signed'(in_tdata[4*C-1:3*C])),
    .rect_x      (signed'(in_tdata[5*C-1:4*C])),
    .rect_y      (signed'(in_tdata[6*C-1:5*C])),
    .rect_w      (in_tdata[6*C+EXT_BITS-1:6*C]),
    .rect_h      (in_tdata[6*C+2*EXT_BITS-1:6*C+EXT_BITS]),
    .ctl         (e_ctl),
    .div_d       (e_d),
    .num_a       (e_na),
    .num_b       (e_nb),
    .base        (e_base),
    .along       (e_along)
  );

  sri_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (e_ctl),
    .div_d   (e_d),
    .num_a   (e_na),
    .num_b   (e_nb),
    .base_i  (e_base),
    .along_i (e_along),
    .ctl_o   (d_ctl),
    .quo     (d_quo),
    .frac    (d_frac),
    .base_o  (d_base),
    .along_o (d_along)
  );

  sri_place #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (d_ctl),
    .quo     (d_quo),
    .frac    (d_frac),
    .base_i  (d_base),
    .along_i (d_along),
    .ctl_o   (p_ctl),
    .point_x (p_px),
    .point_y (p_py)
  );

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (sk_vld_r) begin
        out_vld_r <= 1'b1;
        sk_vld_r  <= 1'b0;
      end else begin
        out_vld_r <= p_ctl.vld;
      end
    end else if (en && p_ctl.vld) begin
      sk_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      if (sk_vld_r) begin
        out_hit_r  <= sk_hit_r;
        out_edge_r <= sk_edge_r;
        out_px_r   <= sk_px_r;
        out_py_r   <= sk_py_r;
      end else begin
        out_hit_r  <= p_ctl.hit;
        out_edge_r <= p_ctl.hit ? p_ctl.edge_sel : EDGE_LEFT;
        out_px_r   <= p_px;
        out_py_r   <= p_py;
      end
    end else if (en) begin
      sk_hit_r  <= p_ctl.hit;
      sk_edge_r <= p_ctl.hit ? p_ctl.edge_sel : EDGE_LEFT;
      sk_px_r   <= p_px;
      sk_py_r   <= p_py;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_py_r, out_px_r};
  assign out_tuser  = {out_edge_r, out_hit_r};

endmodule

// File: rtl/core/sri_chk.sv
module sri_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sri_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic [sri_pkg::OUT_USER_BITS-1:0] out_tuser
);
  import sri_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a miss carries no edge and no point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && out_tuser[2:1] == EDGE_LEFT)
    else $error("miss with nonzero payload");

  // input side only backs up when a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // a full skid entry stays full while the output is not taken
  a_skid_keep: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !out_tready |=> !in_tready)
    else $error("skid entry dropped under stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipe not empty after reset");

endmodule

bind segment_rectangle_intersect sri_chk u_sri_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
